### design/cpf_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the packet framer.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none
package cpf_pkg;

  localparam int BURST_MAX   = 5;
  localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'h0000;
  localparam logic [7:0]  MARKER_RESET = 8'hFF;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  // One accepted request as held in the input register.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } item_t;

  // The bytes that one request produces, slot 0 goes out first.
  typedef struct packed {
    logic [BURST_CNT_W-1:0]    cnt;
    logic [BURST_MAX-1:0]      eop;
    logic [BURST_MAX-1:0][7:0] bytes;
  } burst_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### design/cpf_framer.sv
// Packet state (CRC, remaining count, open flag) and the burst of bytes for one request.
// Depends on cpf_pkg for the item and burst types and the CRC byte update.
`default_nettype none
module cpf_framer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          consume,
  input  wire cpf_pkg::item_t item,
  input  wire logic [7:0]    start_marker,
  output cpf_pkg::burst_t    burst
);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        open_r, open_nxt;

  logic [15:0] crc_hdr_len;
  logic [15:0] crc_hdr;
  logic [15:0] crc_pay;
  logic [7:0]  rem_dec;

  assign crc_hdr_len = cpf_pkg::crc_byte(cpf_pkg::CRC_INIT, item.payload_length);
  assign crc_hdr     = cpf_pkg::crc_byte(crc_hdr_len, item.command);
  assign crc_pay     = cpf_pkg::crc_byte(crc_r, item.data_byte);
  assign rem_dec     = rem_r - 8'd1;

  always_comb begin
    burst    = '0;
    crc_nxt  = crc_r;
    rem_nxt  = rem_r;
    open_nxt = open_r;
    case (item.kind)
      cpf_pkg::KIND_HEADER: begin
        // A header always restarts the packet, abandoning any open one.
        burst.bytes[0] = start_marker;
        burst.bytes[1] = item.payload_length;
        burst.bytes[2] = item.command;
        burst.bytes[3] = crc_hdr[15:8];
        burst.bytes[4] = crc_hdr[7:0];
        crc_nxt = crc_hdr;
        if (item.payload_length == 8'd0) begin
          burst.cnt    = cpf_pkg::BURST_CNT_W'(5);
          burst.eop[4] = 1'b1;
          rem_nxt      = 8'd0;
          open_nxt     = 1'b0;
        end else begin
          burst.cnt = cpf_pkg::BURST_CNT_W'(3);
          rem_nxt   = item.payload_length;
          open_nxt  = 1'b1;
        end
      end
      cpf_pkg::KIND_PAYLOAD: begin
        if (open_r) begin
          burst.bytes[0] = item.data_byte;
          burst.bytes[1] = crc_pay[15:8];
          burst.bytes[2] = crc_pay[7:0];
          crc_nxt = crc_pay;
          if (rem_dec == 8'd0) begin
            burst.cnt    = cpf_pkg::BURST_CNT_W'(3);
            burst.eop[2] = 1'b1;
            rem_nxt      = 8'd0;
            open_nxt     = 1'b0;
          end else begin
            burst.cnt = cpf_pkg::BURST_CNT_W'(1);
            rem_nxt   = rem_dec;
          end
        end
      end
      default: begin
        burst = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      rem_r  <= '0;
      open_r <= 1'b0;
    end else if (consume) begin
      crc_r  <= crc_nxt;
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
    end
  end

  // An open packet always expects at least one more payload byte.
  a_open_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (rem_r != 8'd0))
    else $error("packet open with no bytes remaining");

endmodule
`default_nettype wire

### design/cpf_out_buf.sv
// Output shift buffer: holds one burst and presents its bytes one per cycle while out_stall is low.
// Depends on cpf_pkg for the burst type and its size constants.
`default_nettype none
module cpf_out_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire cpf_pkg::burst_t burst,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_end_of_packet
);

  logic [cpf_pkg::BURST_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [cpf_pkg::BURST_MAX-1:0][7:0]   bytes_r, bytes_nxt;
  logic [cpf_pkg::BURST_MAX-1:0]        eop_r, eop_nxt;
  logic                                 take;

  assign out_valid         = (cnt_r != '0);
  assign out_byte          = bytes_r[0];
  assign out_end_of_packet = eop_r[0];
  assign take              = out_valid && !out_stall;
  // A new burst may land when the buffer is empty or its last byte leaves now.
  assign room = (cnt_r == '0) || ((cnt_r == cpf_pkg::BURST_CNT_W'(1)) && take);

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    eop_nxt   = eop_r;
    if (load) begin
      cnt_nxt   = burst.cnt;
      bytes_nxt = burst.bytes;
      eop_nxt   = burst.eop;
    end else if (take) begin
      cnt_nxt = cnt_r - cpf_pkg::BURST_CNT_W'(1);
      for (int i = 0; i < cpf_pkg::BURST_MAX - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
        eop_nxt[i]   = eop_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    eop_r   <= eop_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cpf_pkg::BURST_CNT_W'(cpf_pkg::BURST_MAX))
    else $error("output buffer count out of range");

  // The end-of-packet mark only ever sits on the last byte of a burst.
  a_eop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_packet) |-> (cnt_r == cpf_pkg::BURST_CNT_W'(1)))
    else $error("end of packet ahead of the last buffered byte");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (cnt_r > cpf_pkg::BURST_CNT_W'(1))) |=>
      (cnt_r == $past(cnt_r) - cpf_pkg::BURST_CNT_W'(1)))
    else $error("output buffer lost or repeated a byte");

endmodule
`default_nettype wire

### design/command_packet_framer_crc16.sv
// Top level of the command packet framer: input register, marker register, framer, output buffer.
// Depends on cpf_pkg, cpf_framer and cpf_out_buf.
//
//   channel | ports                                       | direction
//   in      | in_valid in_stall in_kind in_command        | request in
//           | in_payload_length in_data_byte              |
//   out     | out_valid out_stall out_byte                | byte out
//           | out_end_of_packet                           |
//   cfg     | cfg_we cfg_data                             | marker write
//
// A request is held in the input register, then its 0 to 5 bytes land in the
// output buffer in one step and leave one per cycle while out_stall is low.
// Mid-packet payload requests sustain one per cycle while out_stall is low; after a header (3 or 5
// bytes) or a closing payload byte (3 bytes) the input waits until they leave the single output byte lane.
// Reset clears the packet state, the buffer count and sets the marker to 0xFF.
// out_stall holds the buffer and, once the buffer cannot take the next burst, raises in_stall.
`default_nettype none
module command_packet_framer_crc16 (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_command,
  input  wire logic [7:0] in_payload_length,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_end_of_packet,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data
);

  logic            in_v_r, in_v_nxt;
  cpf_pkg::item_t  item_r;
  logic [7:0]      marker_r;
  logic            room;
  logic            consume;
  logic            accept;
  cpf_pkg::burst_t burst;

  assign consume  = in_v_r && room;
  assign in_stall = in_v_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (accept) begin
      in_v_nxt = 1'b1;
    end else if (consume) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      marker_r <= cpf_pkg::MARKER_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_we) begin
        marker_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.kind           <= cpf_pkg::kind_t'(in_kind);
      item_r.command        <= in_command;
      item_r.payload_length <= in_payload_length;
      item_r.data_byte      <= in_data_byte;
    end
  end

  cpf_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .consume      (consume),
    .item         (item_r),
    .start_marker (marker_r),
    .burst        (burst)
  );

  cpf_out_buf u_out_buf (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (consume),
    .burst             (burst),
    .room              (room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_end_of_packet (out_end_of_packet)
  );

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for command_packet_framer_crc16: random bursts drive requests,
// and an in-bench framer with its own CRC-16/XMODEM predicts every wire byte.
// Depends on cpf_pkg for the request kind and the reset marker and CRC constants.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    cpf_pkg::kind_t kind;
    logic [7:0]     command;
    logic [7:0]     payload_length;
    logic [7:0]     data_byte;
  } req_t;

  typedef struct {
    logic [7:0] value;
    logic       eop;
  } wire_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_kind = 1'b0;
  logic [7:0] in_command = 8'h00;
  logic [7:0] in_payload_length = 8'h00;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_end_of_packet;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  command_packet_framer_crc16 uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_command        (in_command),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_end_of_packet (out_end_of_packet),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  req_t       req_q[$];
  wire_byte_t wire_q[$];

  // Framer state as the block should hold it.
  logic [15:0] crc_run = cpf_pkg::CRC_INIT;
  logic [7:0]  left_cnt = 8'h00;
  logic        pkt_open = 1'b0;
  logic [7:0]  marker_val = cpf_pkg::MARKER_RESET;

  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_closed = 0;
  int n_abandoned = 0;
  int n_ignored = 0;
  int n_markers = 1;
  int cycles = 0;

  function automatic logic [15:0] crc_xmodem(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) r = {r[14:0], 1'b0} ^ cpf_pkg::CRC_POLY;
      else r = {r[14:0], 1'b0};
    end
    return r;
  endfunction

  task automatic expect_byte(input logic [7:0] v, input logic eop);
    wire_byte_t w;
    w.value = v;
    w.eop = eop;
    wire_q.push_back(w);
  endtask

  task automatic close_packet();
    expect_byte(crc_run[15:8], 1'b0);
    expect_byte(crc_run[7:0], 1'b1);
    pkt_open = 1'b0;
    left_cnt = 8'h00;
    n_closed++;
  endtask

  // Works out the wire bytes that one accepted request causes.
  task automatic frame_request(input req_t r);
    if (r.kind == cpf_pkg::KIND_HEADER) begin
      if (pkt_open) n_abandoned++;
      crc_run = crc_xmodem(crc_xmodem(cpf_pkg::CRC_INIT, r.payload_length), r.command);
      expect_byte(marker_val, 1'b0);
      expect_byte(r.payload_length, 1'b0);
      expect_byte(r.command, 1'b0);
      if (r.payload_length == 8'h00) begin
        close_packet();
      end else begin
        left_cnt = r.payload_length;
        pkt_open = 1'b1;
      end
    end else if (!pkt_open) begin
      n_ignored++;
    end else begin
      crc_run = crc_xmodem(crc_run, r.data_byte);
      expect_byte(r.data_byte, 1'b0);
      left_cnt = left_cnt - 8'd1;
      if (left_cnt == 8'h00) close_packet();
    end
  endtask

  task automatic push_req(input cpf_pkg::kind_t k, input logic [7:0] cmd,
                          input logic [7:0] len, input logic [7:0] data);
    req_t r;
    r.kind = k;
    r.command = cmd;
    r.payload_length = len;
    r.data_byte = data;
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_header(input int len);
    push_req(cpf_pkg::KIND_HEADER, 8'($urandom), 8'(len), 8'($urandom));
  endtask

  task automatic push_payload();
    push_req(cpf_pkg::KIND_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Mostly complete packets with random content; the rest are zero-length headers,
  // packets cut short by the next header, and stray payload bytes.
  task automatic random_traffic(input int target);
    int made, pick, len, cnt;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        push_header(len);
        for (int k = 0; k < len; k++) push_payload();
        made += len + 1;
      end else if (pick == 7) begin
        len = $urandom_range(1, 255);
        cnt = $urandom_range(0, (len > 4) ? 4 : len - 1);
        push_header(len);
        for (int k = 0; k < cnt; k++) push_payload();
        made += cnt + 1;
      end else if (pick == 8) begin
        cnt = $urandom_range(1, 2);
        for (int k = 0; k < cnt; k++) push_payload();
      end else begin
        push_header(0);
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_queued || wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_marker(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker_val = v;
    n_markers++;
  endtask

  task automatic report_mismatch(input string field, input int exp_v, input int act_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $error("%s: expected %0h, got %0h", field, exp_v, act_v);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int   burst_left = 0;
  int   gap_left = 0;
  req_t cur_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_request(cur_req);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_req.kind;
          in_command <= cur_req.command;
          in_payload_length <= cur_req.payload_length;
          in_data_byte <= cur_req.data_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches among no stall, random stall and long stall runs.
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (wire_q.size() == 0) begin
        report_mismatch("unexpected out_byte", 0, out_byte);
      end else begin
        wire_byte_t w;
        w = wire_q.pop_front();
        n_checked++;
        if (out_byte !== w.value) report_mismatch("out_byte", w.value, out_byte);
        if (out_end_of_packet !== w.eop)
          report_mismatch("out_end_of_packet", w.eop, out_end_of_packet);
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    if (stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall <= 1'($urandom_range(0, 1));
    end else if (run_left == 0) begin
      out_stall <= ~out_stall;
      run_left = $urandom_range(1, 8);
    end else begin
      run_left--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset marker.
    push_req(cpf_pkg::KIND_HEADER, 8'h00, 8'h00, 8'hFF);
    push_req(cpf_pkg::KIND_HEADER, 8'hFF, 8'h00, 8'h00);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'hFF, 8'hFF, 8'hAA);   // nothing open, so ignored
    push_req(cpf_pkg::KIND_HEADER, 8'h5A, 8'h02, 8'h00);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h00);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    push_req(cpf_pkg::KIND_HEADER, 8'h81, 8'hFF, 8'h55);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h12);
    // A new header cuts the open packet short.
    push_req(cpf_pkg::KIND_HEADER, 8'h7E, 8'h01, 8'h00);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'hC3);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'h00, 8'h00, 8'h3C);
    push_req(cpf_pkg::KIND_HEADER, 8'hA5, 8'h80, 8'h00);
    push_req(cpf_pkg::KIND_HEADER, 8'h01, 8'h01, 8'h00);
    push_req(cpf_pkg::KIND_PAYLOAD, 8'hFF, 8'hFF, 8'h80);
    wait_idle();

    write_marker(8'h00);
    random_traffic(32);
    wait_idle();

    write_marker(8'($urandom_range(1, 254)));
    random_traffic(32);
    wait_idle();

    write_marker(8'hFF);
    random_traffic(32);
    wait_idle();

    if (wire_q.size() != 0) report_mismatch("bytes left over", 0, wire_q.size());
    $display("%0d requests, %0d wire bytes checked under %0d marker settings", n_accepted,
             n_checked, n_markers);
    $display("%0d packets closed, %0d cut short, %0d stray payload bytes", n_closed,
             n_abandoned, n_ignored);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
design/cpf_pkg.sv
design/cpf_framer.sv
design/cpf_out_buf.sv
design/command_packet_framer_crc16.sv
tb/tb.sv
